>>> rtl/ordl_pkg.sv
// Shared types and constants for the ordered list block.
// Used by ordl_cell and ordered_list_insert_delete; no dependencies.
`timescale 1ns / 1ps

package ordl_pkg;

    // Default list capacity and fixed field widths
    localparam int CAPACITY_DEF = 16;
    localparam int OP_W         = 3;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 5;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;

    // Operation codes carried by a request
    typedef enum logic [OP_W-1:0] {
        OP_INS_TAIL = 3'd0,
        OP_INS_HEAD = 3'd1,
        OP_DEL_HEAD = 3'd2,
        OP_INS_AT   = 3'd3,
        OP_DEL_AT   = 3'd4,
        OP_READ_OUT = 3'd5
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADIDX = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Per-cell load selects; at most one is set, none means hold
    typedef struct packed {
        logic take_bcast;
        logic take_left;
        logic take_right;
    } t_cell_ctl;

endpackage

>>> rtl/ordl_cell.sv
// One storage cell of the list: holds a single element and loads from its
// left or right neighbor or from the shared broadcast bus. Depends on ordl_pkg.
`timescale 1ns / 1ps

module ordl_cell (
    input  logic                                   i_clk,
    input  ordl_pkg::t_cell_ctl                    i_ctl,
    input  logic signed [ordl_pkg::VALUE_W-1:0]    i_bcast,
    input  logic signed [ordl_pkg::VALUE_W-1:0]    i_left,
    input  logic signed [ordl_pkg::VALUE_W-1:0]    i_right,
    output logic signed [ordl_pkg::VALUE_W-1:0]    o_q
);

    logic signed [ordl_pkg::VALUE_W-1:0] r_q;
    logic signed [ordl_pkg::VALUE_W-1:0] n_q;

    // Source select: broadcast wins, then shift right (insert), then shift left
    always_comb begin
        if (i_ctl.take_bcast) begin
            n_q = i_bcast;
        end else if (i_ctl.take_left) begin
            n_q = i_left;
        end else if (i_ctl.take_right) begin
            n_q = i_right;
        end else begin
            n_q = r_q;
        end
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

>>> rtl/ordered_list_insert_delete.sv
// Bounded ordered list held in a chain of shift cells (head in cell 0).
// Edits (insert/delete at head, tail or index): result registered in the cycle
// after the request, a new request every cycle while not busy. Read out of N
// elements: busy, one result per cycle as the chain rotates past cell 0.
// Synchronous active-low reset empties the list; element storage is not reset.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
`timescale 1ns / 1ps

module ordered_list_insert_delete #(
    parameter int CAPACITY = ordl_pkg::CAPACITY_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [ordl_pkg::OP_W-1:0]               i_operation,
    input  logic signed [ordl_pkg::VALUE_W-1:0]     i_value,
    input  logic [ordl_pkg::POS_W-1:0]              i_position,
    output logic                                    o_valid,
    output logic [ordl_pkg::STATUS_W-1:0]           o_status,
    output logic signed [ordl_pkg::VALUE_W-1:0]     o_element,
    output logic [ordl_pkg::COUNT_W-1:0]            o_count,
    output logic                                    o_last
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);
    localparam int CMP_W = (CW > ordl_pkg::POS_W) ? CW : ordl_pkg::POS_W;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    t_state                                  r_state;
    logic                                    r_valid;
    logic [CW-1:0]                           r_occ;
    logic [CW-1:0]                           n_occ;
    logic [IW-1:0]                           r_rd_idx;
    ordl_pkg::t_status                       r_status;
    logic signed [ordl_pkg::VALUE_W-1:0]     r_element;
    logic [ordl_pkg::COUNT_W-1:0]            r_count;
    logic                                    r_last;

    logic                                    accept;
    logic                                    full;
    logic                                    rot;
    logic                                    rd_last;
    logic                                    ins_en;
    logic                                    del_en;
    logic                                    rd_en;
    logic                                    ins_fire;
    logic                                    del_fire;
    logic                                    rd_fire;
    logic [CW-1:0]                           edit_pos;
    logic [CW-1:0]                           occ_m1;
    logic [CMP_W-1:0]                        pos_c;
    logic [CMP_W-1:0]                        occ_c;
    ordl_pkg::t_status                       res_status;
    logic signed [ordl_pkg::VALUE_W-1:0]     bcast;

    ordl_pkg::t_cell_ctl                     cell_ctl [CAPACITY];
    logic signed [ordl_pkg::VALUE_W-1:0]     cell_q   [CAPACITY];

    assign busy     = (r_state == ST_READ);
    assign accept   = start && !busy;
    assign rot      = (r_state == ST_READ);
    assign full     = (r_occ == CW'(CAPACITY));
    assign occ_m1   = r_occ - CW'(1);
    assign pos_c    = CMP_W'(i_position);
    assign occ_c    = CMP_W'(r_occ);
    assign rd_last  = (CW'(r_rd_idx) == occ_m1);

    // Request decode: status and which edit, if any
    always_comb begin
        ins_en     = 1'b0;
        del_en     = 1'b0;
        rd_en      = 1'b0;
        edit_pos   = '0;
        res_status = ordl_pkg::ST_OK;
        case (ordl_pkg::t_op'(i_operation))
            ordl_pkg::OP_INS_TAIL: begin
                if (full) begin
                    res_status = ordl_pkg::ST_FULL;
                end else begin
                    ins_en   = 1'b1;
                    edit_pos = r_occ;
                end
            end
            ordl_pkg::OP_INS_HEAD: begin
                if (full) begin
                    res_status = ordl_pkg::ST_FULL;
                end else begin
                    ins_en = 1'b1;
                end
            end
            ordl_pkg::OP_DEL_HEAD: begin
                if (r_occ == '0) begin
                    res_status = ordl_pkg::ST_EMPTY;
                end else begin
                    del_en = 1'b1;
                end
            end
            ordl_pkg::OP_INS_AT: begin
                // index checked before fullness
                if (pos_c > occ_c) begin
                    res_status = ordl_pkg::ST_BADIDX;
                end else if (full) begin
                    res_status = ordl_pkg::ST_FULL;
                end else begin
                    ins_en   = 1'b1;
                    edit_pos = CW'(i_position);
                end
            end
            ordl_pkg::OP_DEL_AT: begin
                // emptiness checked before index
                if (r_occ == '0) begin
                    res_status = ordl_pkg::ST_EMPTY;
                end else if (pos_c >= occ_c) begin
                    res_status = ordl_pkg::ST_BADIDX;
                end else begin
                    del_en   = 1'b1;
                    edit_pos = CW'(i_position);
                end
            end
            ordl_pkg::OP_READ_OUT: begin
                if (r_occ == '0) begin
                    res_status = ordl_pkg::ST_EMPTY;
                end else begin
                    rd_en = 1'b1;
                end
            end
            default: begin
                res_status = ordl_pkg::ST_OK;
            end
        endcase
    end

    assign ins_fire = accept && ins_en;
    assign del_fire = accept && del_en;
    assign rd_fire  = accept && rd_en;

    // Next occupancy
    always_comb begin
        if (ins_fire) begin
            n_occ = r_occ + CW'(1);
        end else if (del_fire) begin
            n_occ = r_occ - CW'(1);
        end else begin
            n_occ = r_occ;
        end
    end

    // Broadcast: new value on insert, head wraps to tail slot on rotate
    assign bcast = rot ? cell_q[0] : i_value;

    // Per-cell selects
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_ctl[i].take_bcast = (ins_fire && (CW'(i) == edit_pos))
                                  || (rot && (CW'(i) == occ_m1));
            cell_ctl[i].take_left  = ins_fire && (CW'(i) > edit_pos);
            cell_ctl[i].take_right = (del_fire && (CW'(i) >= edit_pos))
                                  || (rot && (CW'(i) < occ_m1));
        end
    end

    // Cell chain; ends tie to the broadcast bus (head end never selected there)
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [ordl_pkg::VALUE_W-1:0] left_d;
        logic signed [ordl_pkg::VALUE_W-1:0] right_d;

        if (g == 0) begin : g_head
            assign left_d = bcast;
        end else begin : g_mid_l
            assign left_d = cell_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_d = bcast;
        end else begin : g_mid_r
            assign right_d = cell_q[g+1];
        end

        ordl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_bcast (bcast),
            .i_left  (left_d),
            .i_right (right_d),
            .o_q     (cell_q[g])
        );
    end

    // Control state and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= 1'b0;
            r_occ    <= '0;
            r_rd_idx <= '0;
        end else begin
            r_occ <= n_occ;
            case (r_state)
                ST_IDLE: begin
                    r_valid   <= accept && !rd_en;
                    r_status  <= res_status;
                    r_element <= '0;
                    r_count   <= ordl_pkg::COUNT_W'(n_occ);
                    r_last    <= 1'b1;
                    r_rd_idx  <= '0;
                    if (rd_fire) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_valid   <= 1'b1;
                    r_status  <= ordl_pkg::ST_OK;
                    r_element <= cell_q[0];
                    r_count   <= ordl_pkg::COUNT_W'(r_occ);
                    r_last    <= rd_last;
                    r_rd_idx  <= r_rd_idx + IW'(1);
                    if (rd_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_element = r_element;
    assign o_count   = r_count;
    assign o_last    = r_last;

`ifndef SYNTHESIS
    // Occupancy never exceeds the number of cells
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    // A read out only runs on a non-empty list
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_occ != '0))
        else $error("read out on empty list");

    // Read out results come back to back until the last one
    a_read_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("gap inside read out burst");

    // Occupancy does not change during a read out
    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> $stable(r_occ))
        else $error("occupancy changed during read out");
`endif

endmodule
